// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, pre, post) \
    lbl: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/pcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pcf_pkg
// shared types, constants and helpers of the piecewise cubic evaluator
// ----------------------------------------------------------------------------
package pcf_pkg;

    // table geometry
    localparam int ROWS  = 64;
    localparam int ROW_W = $clog2(ROWS);

    // request codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // value of the most negative 32-bit word
    localparam logic [31:0] MIN_WORD = 32'h8000_0000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_LOAD,
        S_MUL,
        S_MWAIT,
        S_ADD,
        S_AWAIT
    } t_state;

    // one stored table row besides its breakpoint
    typedef struct packed {
        logic [31:0] c3;
        logic [31:0] c2;
        logic [31:0] c1;
        logic [31:0] c0;
        logic [31:0] sw;
    } t_row;

    // table access from the sequencer
    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] waddr;
        logic [ROW_W-1:0] bp_raddr;
        logic [ROW_W-1:0] row_raddr;
    } t_tbl_req;

    // operation issued to the shared arithmetic unit
    typedef struct packed {
        logic               mul_go;
        logic               add_go;
        logic [31:0]        a;
        logic [31:0]        b;
        logic signed [6:0]  sh;
    } t_mac_req;

    // registered result of the shared arithmetic unit
    typedef struct packed {
        logic [31:0] res;
        logic        ov;
    } t_mac_rsp;

    // signed 8-bit shift clamped to -63..63
    function automatic logic signed [6:0] shift_clamp(input logic [7:0] b);
        logic signed [7:0] s;
        s = $signed(b);
        if (s > 8'sd63) begin
            return 7'sd63;
        end else if (s < -8'sd63) begin
            return -7'sd63;
        end
        return 7'(s);
    endfunction

endpackage

// ===== rtl/pcf_table.sv =====
// ----------------------------------------------------------------------------
// pcf_table
// breakpoint memory and row memory (coefficients and shift word)
// ----------------------------------------------------------------------------
module pcf_table import pcf_pkg::*; (
    input  logic        i_clk,
    input  t_tbl_req    i_req,
    input  logic [31:0] i_bp_wdata,
    input  t_row        i_row_wdata,
    output logic [31:0] o_bp_rd,
    output t_row        o_row_rd
);

    logic [31:0] r_bp_mem  [ROWS];
    t_row        r_row_mem [ROWS];
    logic [31:0] r_bp_rd;
    t_row        r_row_rd;

    // one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_bp_mem[i_req.waddr]  <= i_bp_wdata;
            r_row_mem[i_req.waddr] <= i_row_wdata;
        end
        r_bp_rd  <= r_bp_mem[i_req.bp_raddr];
        r_row_rd <= r_row_mem[i_req.row_raddr];
    end

    assign o_bp_rd  = r_bp_rd;
    assign o_row_rd = r_row_rd;

endmodule

// ===== rtl/pcf_mac.sv =====
// ----------------------------------------------------------------------------
// pcf_mac
// shared sign-magnitude multiply with shift, and 32-bit wide add
// ----------------------------------------------------------------------------
module pcf_mac import pcf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mac_req i_req,
    output t_mac_rsp o_rsp
);

    logic [31:0]       a_mag;
    logic [31:0]       b_mag;
    logic [63:0]       r_prod;
    logic              r_neg;
    logic signed [6:0] r_sh;
    logic              r_mul_v;
    logic [6:0]        neg_sh;
    logic [63:0]       sr;
    logic [127:0]      sl;
    logic [31:0]       mag;
    logic              mul_ov;
    logic [31:0]       mul_res;
    logic [31:0]       add_res;
    logic              add_ov;
    logic [31:0]       r_res;
    logic              r_ov;

    // stage one: magnitudes and product
    assign a_mag = i_req.a[31] ? 32'(-i_req.a) : i_req.a;
    assign b_mag = i_req.b[31] ? 32'(-i_req.b) : i_req.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else begin
            r_mul_v <= i_req.mul_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.mul_go) begin
            r_prod <= a_mag * b_mag;
            r_neg  <= i_req.a[31] ^ i_req.b[31];
            r_sh   <= i_req.sh;
        end
    end

    // stage two: shift, range check, sign
    always_comb begin
        neg_sh = 7'(-r_sh);
        sr     = r_prod >> r_sh[5:0];
        sl     = {64'd0, r_prod} << neg_sh[5:0];
        if (r_sh[6]) begin
            mag    = sl[31:0];
            mul_ov = |sl[127:32];
        end else begin
            mag    = sr[31:0];
            mul_ov = |sr[63:32];
        end
        mul_res = r_neg ? 32'(-mag) : mag;
    end

    // add: only two most negative words reach a magnitude of 2^32
    assign add_res = i_req.a + i_req.b;
    assign add_ov  = (i_req.a == MIN_WORD) && (i_req.b == MIN_WORD);

    // shared result register
    always_ff @(posedge i_clk) begin
        if (r_mul_v) begin
            r_res <= mul_res;
            r_ov  <= mul_ov;
        end else if (i_req.add_go) begin
            r_res <= add_res;
            r_ov  <= add_ov;
        end
    end

    assign o_rsp.res = r_res;
    assign o_rsp.ov  = r_ov;

endmodule

// ===== rtl/pcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcf_ctrl
// sequencer: row writes, binary segment search and horner steps
// ----------------------------------------------------------------------------
module pcf_ctrl import pcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_cmd,
    input  logic [5:0]  i_row_index,
    input  logic [31:0] i_query_x,
    input  logic        i_cfg_valid,
    input  logic [6:0]  i_cfg_data,
    output t_tbl_req    o_tbl,
    input  logic [31:0] i_bp_rd,
    input  t_row        i_row_rd,
    output t_mac_req    o_mac,
    input  t_mac_rsp    i_mac,
    output logic        o_busy,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic [5:0]  o_segment,
    output logic        o_overflow
);

    t_state           r_state, n_state;
    logic [6:0]       r_num_rows;
    logic [31:0]      r_q, n_q;
    logic [ROW_W-1:0] r_lo, n_lo;
    logic [ROW_W-1:0] r_hi, n_hi;
    logic [ROW_W-1:0] r_k, n_k;
    logic [31:0]      r_dx, n_dx;
    t_row             r_row, n_row;
    logic [31:0]      r_acc, n_acc;
    logic [1:0]       r_step, n_step;
    logic             r_ov, n_ov;
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_value, n_value;
    logic [5:0]       r_segment, n_segment;
    logic             r_out_ov, n_out_ov;

    logic             accept;
    logic [31:0]      rows_used;
    logic [ROW_W-1:0] mid;
    logic             more;
    logic [7:0]       sh_byte;
    logic [31:0]      add_coef;

    assign accept = i_start && (r_state == S_IDLE);

    // effective row count, clamped to 2..ROWS
    always_comb begin
        rows_used = 32'(r_num_rows);
        if (rows_used < 32'd2) begin
            rows_used = 32'd2;
        end
        if (rows_used > 32'(ROWS)) begin
            rows_used = 32'(ROWS);
        end
    end

    // search midpoint and loop test
    assign mid  = ROW_W'(({1'b0, r_hi} + {1'b0, r_lo}) >> 1);
    assign more = (r_hi - r_lo) > ROW_W'(1);

    // per-step shift byte and coefficient
    always_comb begin
        case (r_step)
            2'd0: begin
                sh_byte  = r_row.sw[31:24];
                add_coef = r_row.c2;
            end
            2'd1: begin
                sh_byte  = r_row.sw[23:16];
                add_coef = r_row.c1;
            end
            2'd2: begin
                sh_byte  = r_row.sw[15:8];
                add_coef = r_row.c0;
            end
            default: begin
                sh_byte  = r_row.sw[7:0];
                add_coef = r_row.c0;
            end
        endcase
    end

    // table access
    always_comb begin
        o_tbl.we        = accept && (i_cmd == CMD_WRITE) && (32'(i_row_index) < 32'(ROWS));
        o_tbl.waddr     = ROW_W'(i_row_index);
        o_tbl.bp_raddr  = more ? mid : r_lo;
        o_tbl.row_raddr = r_lo;
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= 7'd2;
        end else if (i_cfg_valid) begin
            r_num_rows <= i_cfg_data;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_q       <= n_q;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_k       <= n_k;
        r_dx      <= n_dx;
        r_row     <= n_row;
        r_acc     <= n_acc;
        r_step    <= n_step;
        r_ov      <= n_ov;
        r_value   <= n_value;
        r_segment <= n_segment;
        r_out_ov  <= n_out_ov;
    end

    // next state and unit requests
    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_k         = r_k;
        n_dx        = r_dx;
        n_row       = r_row;
        n_acc       = r_acc;
        n_step      = r_step;
        n_ov        = r_ov;
        n_out_valid = 1'b0;
        n_value     = r_value;
        n_segment   = r_segment;
        n_out_ov    = r_out_ov;
        o_mac.mul_go = 1'b0;
        o_mac.add_go = 1'b0;
        o_mac.a      = r_acc;
        o_mac.b      = r_dx;
        o_mac.sh     = shift_clamp(sh_byte);

        case (r_state)
            S_IDLE: begin
                if (accept && (i_cmd == CMD_EVAL)) begin
                    n_q     = i_query_x;
                    n_lo    = '0;
                    n_hi    = ROW_W'(rows_used - 32'd1);
                    n_ov    = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            // read the midpoint, or the selected row when the search is done
            S_SEARCH: begin
                n_k = mid;
                if (more) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_CMP: begin
                if ($signed(i_bp_rd) > $signed(r_q)) begin
                    n_hi = r_k;
                end else begin
                    n_lo = r_k;
                end
                n_state = S_SEARCH;
            end
            S_LOAD: begin
                n_dx    = r_q - i_bp_rd;
                n_row   = i_row_rd;
                n_acc   = i_row_rd.c3;
                n_step  = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_mac.mul_go = 1'b1;
                if (r_step == 2'd3) begin
                    o_mac.b = 32'd1;
                end
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                n_state = S_ADD;
            end
            // product ready: either finish or add the next coefficient
            S_ADD: begin
                n_ov = r_ov | i_mac.ov;
                if (r_step == 2'd3) begin
                    n_out_valid = 1'b1;
                    n_value     = i_mac.res;
                    n_segment   = 6'(r_lo);
                    n_out_ov    = r_ov | i_mac.ov;
                    n_state     = S_IDLE;
                end else begin
                    o_mac.add_go = 1'b1;
                    o_mac.a      = i_mac.res;
                    o_mac.b      = add_coef;
                    n_state      = S_AWAIT;
                end
            end
            S_AWAIT: begin
                n_ov    = r_ov | i_mac.ov;
                n_acc   = i_mac.res;
                n_step  = r_step + 2'd1;
                n_state = S_MUL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_segment  = r_segment;
    assign o_overflow = r_out_ov;

endmodule

// ===== rtl/piecewise_cubic_fixed_point_eval.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_fixed_point_eval
// Piecewise cubic table evaluator, fixed point, one shared multiplier.
// A request is taken when start is high and busy is low. i_cmd selects a row
// write (stores breakpoint, four coefficients and shift word together,
// busy stays low, no result) or an evaluation at i_query_x.
// An evaluation holds busy over I search steps on the n rows in use, I between
// floor and ceil of log2(n - 1) depending on the data (at most 6 for 64 rows):
// each search step reads the breakpoint memory and compares, then come four
// multiply-shift passes through the two-stage multiplier, the first three each
// followed by an add of the next coefficient in the adder.
// The result shows on o_value, o_segment, o_overflow for one cycle with
// o_valid, in the first cycle busy is low again; the receiver cannot stall.
// num_rows is written through i_cfg_valid / i_cfg_data, always ready; write
// it only while idle. Reset sets num_rows to 2 and drops busy and o_valid;
// table contents are undefined until written and no clearing pass is run.
// ----------------------------------------------------------------------------
module piecewise_cubic_fixed_point_eval import pcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [5:0]  i_row_index,
    input  logic [31:0] i_row_x,
    input  logic [31:0] i_coef_cubic,
    input  logic [31:0] i_coef_square,
    input  logic [31:0] i_coef_linear,
    input  logic [31:0] i_coef_const,
    input  logic [31:0] i_shift_word,
    input  logic [31:0] i_query_x,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic [5:0]  o_segment,
    output logic        o_overflow
);

    t_tbl_req    tbl_req;
    t_row        row_wdata;
    logic [31:0] bp_rd;
    t_row        row_rd;
    t_mac_req    mac_req;
    t_mac_rsp    mac_rsp;

    // row write data
    assign row_wdata.c3 = i_coef_cubic;
    assign row_wdata.c2 = i_coef_square;
    assign row_wdata.c1 = i_coef_linear;
    assign row_wdata.c0 = i_coef_const;
    assign row_wdata.sw = i_shift_word;

    // register write always completes
    assign o_cfg_ready = 1'b1;

    pcf_table u_table (
        .i_clk       (i_clk),
        .i_req       (tbl_req),
        .i_bp_wdata  (i_row_x),
        .i_row_wdata (row_wdata),
        .o_bp_rd     (bp_rd),
        .o_row_rd    (row_rd)
    );

    pcf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mac_req),
        .o_rsp   (mac_rsp)
    );

    pcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .i_row_index (i_row_index),
        .i_query_x   (i_query_x),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_tbl       (tbl_req),
        .i_bp_rd     (bp_rd),
        .i_row_rd    (row_rd),
        .o_mac       (mac_req),
        .i_mac       (mac_rsp),
        .o_busy      (busy),
        .o_valid     (o_valid),
        .o_value     (o_value),
        .o_segment   (o_segment),
        .o_overflow  (o_overflow)
    );

endmodule

// ===== rtl/pcf_checker.sv =====
// ----------------------------------------------------------------------------
// pcf_checker
// port-level checks of request and result sequencing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pcf_checker import pcf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cmd,
    input logic o_valid
);

    // reset leaves the block idle with no result
    `ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !busy && !o_valid)

    // an evaluation request makes the block busy
    `ASSERT_NEXT(a_eval_busy, i_clk, i_rst_n, start && !busy && (i_cmd == CMD_EVAL), busy)

    // a row write gives no result and leaves the block free
    `ASSERT_NEXT(a_write_quiet, i_clk, i_rst_n, start && !busy && (i_cmd == CMD_WRITE),
        !busy && !o_valid)

    // a result appears only once the block is free again
    `ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_valid, !busy)

    // each result strobe lasts a single cycle
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule

bind piecewise_cubic_fixed_point_eval pcf_checker u_pcf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid)
);
